>>> sv/ssa_pkg.sv
// Shared types and constants of the swap slot allocator.
// No dependencies; every other file imports this package.
`default_nettype none
package ssa_pkg;

	// Bitmap storage is organized in rows of this many slot bits.
	localparam int WORD_BITS = 32;
	localparam int LOG_W     = 5;

	// Field widths of the ports.
	localparam int CFG_W     = 11;
	localparam int STATUS_W  = 2;
	localparam int GSLOT_W   = 10;
	localparam int REQ_W     = 10;
	localparam int SECTOR_W  = 13;

	localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 11'd1024;

	localparam int DEF_SLOTS = 1024;
	localparam int DEF_SPP   = 8;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = 1;
	localparam int QC_W        = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	// One classified request: status and the slot (low bits) to emit a run for.
	typedef struct packed {
		status_t               status;
		logic [SECTOR_W-1:0]   slot;
	} q_entry_t;

endpackage
`default_nettype wire

>>> sv/ssa_front.sv
// Front part of the swap slot allocator: accepts requests, searches and updates
// the slot bitmap memory and pushes one classified command per request. Uses ssa_pkg.
`default_nettype none
module ssa_front #(
	parameter int SLOTS = ssa_pkg::DEF_SLOTS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      func,
	input  wire logic [ssa_pkg::REQ_W-1:0] slot_number,
	input  wire logic [ssa_pkg::CFG_W-1:0] slot_count,
	output logic                           busy,
	output logic                           q_push,
	output ssa_pkg::q_entry_t              q_entry,
	input  wire logic                      q_full
);
	import ssa_pkg::*;

	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int ROWS     = (SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int MEM_ROWS = 1 << ROW_W;
	localparam int IDX_W    = ROW_W + LOG_W;
	localparam int TAIL_W   = LOG_W + 1;

	typedef enum logic [4:0] {
		FS_CLEAR = 5'b00001,
		FS_IDLE  = 5'b00010,
		FS_READ  = 5'b00100,
		FS_EVAL  = 5'b01000,
		FS_PUSH  = 5'b10000
	} fstate_t;

	fstate_t                state_q;
	logic [ROW_W-1:0]       row_q;
	logic                   func_q;
	logic [IDX_W-1:0]       req_q;
	logic [CNT_W-1:0]       limit_q;
	logic [ROW_W-1:0]       last_row_q;
	logic [TAIL_W-1:0]      tail_q;
	q_entry_t               res_q;

	logic [WORD_BITS-1:0]   mem [MEM_ROWS];
	logic [WORD_BITS-1:0]   rdata_q;
	logic                   mem_we;
	logic [WORD_BITS-1:0]   mem_wdata;

	logic [CNT_W-1:0]       lim;
	logic [31:0]            lim_m1;
	logic                   bad_req;
	logic [WORD_BITS-1:0]   row_mask;
	logic [WORD_BITS-1:0]   avail;
	logic                   alloc_found;
	logic [LOG_W-1:0]       pick;
	logic [IDX_W-1:0]       alloc_idx;
	logic                   req_bit;

	// Effective slot count, saturated to the bitmap size.
	always_comb begin
		lim = (32'(slot_count) > 32'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slot_count);
		lim_m1 = 32'(lim) - 32'd1;
		bad_req = func && (32'(slot_number) >= 32'(lim));
	end

	// Lowest free slot in the current row, limited to slots below the count.
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			row_mask[j] = (row_q != last_row_q) || (TAIL_W'(j) < tail_q);
		end
		avail = ~rdata_q & row_mask;
		alloc_found = |avail;
		pick = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (avail[j]) begin
				pick = LOG_W'(j);
			end
		end
		alloc_idx = {row_q, pick};
		req_bit = rdata_q[req_q[LOG_W-1:0]];
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wdata = '0;
		case (state_q)
			FS_CLEAR: begin
				mem_we = 1'b1;
			end
			FS_EVAL: begin
				if (func_q) begin
					mem_we = req_bit;
					mem_wdata = rdata_q & ~(WORD_BITS'(1) << req_q[LOG_W-1:0]);
				end else begin
					mem_we = alloc_found;
					mem_wdata = rdata_q | (WORD_BITS'(1) << pick);
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Bitmap memory: one row written and one row read per cycle, read data registered.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[row_q] <= mem_wdata;
		end
		rdata_q <= mem[row_q];
	end

	// After reset the bitmap is cleared one row per cycle before any request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_CLEAR;
			row_q <= '0;
		end else begin
			case (state_q)
				FS_CLEAR: begin
					if (row_q == ROW_W'(ROWS - 1)) begin
						row_q <= '0;
						state_q <= FS_IDLE;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				FS_IDLE: begin
					if (start) begin
						if (!func) begin
							if (lim == '0) begin
								state_q <= FS_PUSH;
							end else begin
								row_q <= '0;
								state_q <= FS_READ;
							end
						end else if (bad_req) begin
							state_q <= FS_PUSH;
						end else begin
							row_q <= ROW_W'(32'(slot_number) >> LOG_W);
							state_q <= FS_READ;
						end
					end
				end
				FS_READ: begin
					state_q <= FS_EVAL;
				end
				FS_EVAL: begin
					if (func_q || alloc_found || row_q == last_row_q) begin
						state_q <= FS_PUSH;
					end else begin
						row_q <= row_q + ROW_W'(1);
						state_q <= FS_READ;
					end
				end
				FS_PUSH: begin
					if (!q_full) begin
						state_q <= FS_IDLE;
					end
				end
				default: begin
					state_q <= FS_IDLE;
				end
			endcase
		end
	end

	// The command starts out as the error outcome and is replaced on success.
	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && start) begin
			func_q <= func;
			req_q <= IDX_W'(slot_number);
			limit_q <= lim;
			last_row_q <= ROW_W'(lim_m1 >> LOG_W);
			tail_q <= TAIL_W'(lim_m1[LOG_W-1:0]) + TAIL_W'(1);
			res_q.status <= func ? ST_BAD : ST_FULL;
			res_q.slot <= '0;
		end else if (state_q == FS_EVAL) begin
			if (func_q && req_bit) begin
				res_q.status <= ST_OK;
				res_q.slot <= SECTOR_W'(req_q);
			end else if (!func_q && alloc_found) begin
				res_q.status <= ST_OK;
				res_q.slot <= SECTOR_W'(alloc_idx);
			end
		end
	end

	assign busy = (state_q != FS_IDLE);
	assign q_push = (state_q == FS_PUSH) && !q_full;
	assign q_entry = res_q;

`ifndef SYNTHESIS
	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_EVAL && !func_q && alloc_found) |-> (32'(alloc_idx) < 32'(limit_q)))
		else $error("allocated slot lies at or above the slot count");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_READ || state_q == FS_EVAL) |-> (row_q <= last_row_q))
		else $error("bitmap row scanned beyond the last counted row");
`endif

endmodule
`default_nettype wire

>>> sv/ssa_queue.sv
// Short command queue between the front and the back of the swap slot allocator.
// Uses the entry type of ssa_pkg.
`default_nettype none
module ssa_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  ssa_pkg::q_entry_t       push_entry,
	output logic                    full,
	input  wire logic               pop,
	output logic                    valid,
	output ssa_pkg::q_entry_t       head
);
	import ssa_pkg::*;

	q_entry_t           entries_q [QUEUE_DEPTH];
	logic [QP_W-1:0]    wr_ptr_q;
	logic [QP_W-1:0]    rd_ptr_q;
	logic [QC_W-1:0]    count_q;
	logic               do_pop;

	assign full = (count_q == QC_W'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head = entries_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QC_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - QC_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command pushed into a full queue");
`endif

endmodule
`default_nettype wire

>>> sv/ssa_back.sv
// Back part of the swap slot allocator: takes classified commands from the queue
// and emits one result per cycle, a sector run or a single error result. Uses ssa_pkg.
`default_nettype none
module ssa_back #(
	parameter int PAGE_SECTORS = ssa_pkg::DEF_SPP
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  ssa_pkg::q_entry_t                 q_head,
	output logic                              q_pop,
	output logic                              result_strobe,
	output logic [ssa_pkg::STATUS_W-1:0]      status,
	output logic [ssa_pkg::GSLOT_W-1:0]       granted_slot,
	output logic [ssa_pkg::SECTOR_W-1:0]      sector_address,
	output logic                              last_beat
);
	import ssa_pkg::*;

	localparam int BEAT_W = (PAGE_SECTORS > 1) ? $clog2(PAGE_SECTORS) : 1;

	logic                   active_q;
	logic [BEAT_W-1:0]      beat_q;
	logic [SECTOR_W-1:0]    base_q;
	logic [GSLOT_W-1:0]     slot_q;
	logic                   run_last;
	logic [SECTOR_W-1:0]    head_base;

	logic                   strobe_q;
	status_t                status_q;
	logic [GSLOT_W-1:0]     gslot_q;
	logic [SECTOR_W-1:0]    sector_q;
	logic                   last_q;

	assign run_last = active_q && (beat_q == BEAT_W'(PAGE_SECTORS - 1));
	// The next command is taken while the last beat of the current run goes out.
	assign q_pop = q_valid && !active_q;
	assign head_base = SECTOR_W'(32'(q_head.slot) * 32'(PAGE_SECTORS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
			beat_q <= '0;
		end else begin
			strobe_q <= q_pop || active_q;
			if (q_pop) begin
				active_q <= (q_head.status == ST_OK) && (PAGE_SECTORS > 1);
				beat_q <= BEAT_W'(1);
			end else if (active_q) begin
				active_q <= !run_last;
				beat_q <= beat_q + BEAT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			base_q <= head_base;
			slot_q <= GSLOT_W'(q_head.slot);
			status_q <= q_head.status;
			if (q_head.status == ST_OK) begin
				gslot_q <= GSLOT_W'(q_head.slot);
				sector_q <= head_base;
				last_q <= (PAGE_SECTORS == 1);
			end else begin
				gslot_q <= '0;
				sector_q <= '0;
				last_q <= 1'b1;
			end
		end else if (active_q) begin
			status_q <= ST_OK;
			gslot_q <= slot_q;
			sector_q <= base_q + SECTOR_W'(beat_q);
			last_q <= run_last;
		end
	end

	assign result_strobe = strobe_q;
	assign status = status_q;
	assign granted_slot = gslot_q;
	assign sector_address = sector_q;
	assign last_beat = last_q;

`ifndef SYNTHESIS
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && status_q != ST_OK) |-> (last_q && sector_q == '0 && gslot_q == '0))
		else $error("error result is not a single cleared last result");

	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !last_q) |=>
		(strobe_q && status_q == ST_OK && sector_q == $past(sector_q) + SECTOR_W'(1)))
		else $error("sector run broken or not contiguous");
`endif

endmodule
`default_nettype wire

>>> sv/swap_slot_allocator.sv
// Top level of the swap slot allocator: slot count register, front, command queue, back.
// Depends on ssa_pkg, ssa_front, ssa_queue and ssa_back.
//
// Usage. A request (func, slot_number) is taken at a clock edge with start high and
// busy low. func 0 allocates the lowest free slot below the slot count, func 1 frees
// slot_number. Each request gives either PAGE_SECTORS results with consecutive
// sector addresses, last_beat on the final one, or one error result (status full or
// invalid slot) with last_beat set. A result is valid for the one cycle in which
// result_strobe is high; the receiver cannot stall, and none is needed.
// The slot count is written over cfg_valid/cfg_data (cfg_ready is always high); the user
// must write it only while no request is in flight, which the block does not enforce.
// Flow. For each bitmap row of 32 slots that it reads, the front passes a read state
// and then an evaluate state; it reads one row for a free of a slot in range, up to
// ceil(slot_count/32) for an allocate, none when rejected up front. It then waits for
// room in a two-entry queue. The back emits one result per cycle with no gap between
// runs while commands are queued; the front takes new requests while a run goes out.
// A command passes the queue and the back's output registers before its first result.
// Reset. Every slot becomes free and the slot count returns to 1024. The bitmap
// memory is cleared one row per cycle, ceil(SLOTS/32) rows (32 by default), with
// busy high during that pass.
`default_nettype none
module swap_slot_allocator #(
	parameter int SLOTS        = ssa_pkg::DEF_SLOTS,
	parameter int PAGE_SECTORS = ssa_pkg::DEF_SPP
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         func,
	input  wire logic [ssa_pkg::REQ_W-1:0]    slot_number,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [ssa_pkg::CFG_W-1:0]    cfg_data,
	output logic                              result_strobe,
	output logic [ssa_pkg::STATUS_W-1:0]      status,
	output logic [ssa_pkg::GSLOT_W-1:0]       granted_slot,
	output logic [ssa_pkg::SECTOR_W-1:0]      sector_address,
	output logic                              last_beat
);
	import ssa_pkg::*;

	logic [CFG_W-1:0]   slot_count_q;
	logic               q_push;
	q_entry_t           q_in;
	logic               q_full;
	logic               q_pop;
	logic               q_valid;
	q_entry_t           q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			slot_count_q <= cfg_data;
		end
	end

	ssa_front #(
		.SLOTS (SLOTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (func),
		.slot_number (slot_number),
		.slot_count  (slot_count_q),
		.busy        (busy),
		.q_push      (q_push),
		.q_entry     (q_in),
		.q_full      (q_full)
	);

	ssa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	ssa_back #(
		.PAGE_SECTORS (PAGE_SECTORS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.result_strobe  (result_strobe),
		.status         (status),
		.granted_slot   (granted_slot),
		.sector_address (sector_address),
		.last_beat      (last_beat)
	);

endmodule
`default_nettype wire
